### sv/interval_mean_stddev_min_max_assert.svh
// Assertion macros shared by the interval statistics RTL.
`ifndef INTERVAL_MEAN_STDDEV_MIN_MAX_ASSERT_SVH
`define INTERVAL_MEAN_STDDEV_MIN_MAX_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IMSMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define IMSMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/imsmm_pkg.sv
// Shared constants for the interval statistics block.
package imsmm_pkg;

  localparam int OUT_SAMPLE_W = 24;
  localparam int OUT_COUNT_W  = 16;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic [OUT_SAMPLE_W-1:0] MIN_EMPTY = {OUT_SAMPLE_W{1'b1}};

endpackage

### sv/imsmm_front.sv
// Front end: takes input beats, masks the sample, squares it and classifies the command.
module imsmm_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic [imsmm_pkg::OUT_SAMPLE_W-1:0] in_sample,
  output logic                               q_valid,
  input  logic                               q_ready,
  output logic [3*SAMPLE_BITS:0]             q_data
);
  import imsmm_pkg::*;

  localparam int SQ_W = 2 * SAMPLE_BITS;

  logic                   valid_r, valid_nxt;
  logic [3*SAMPLE_BITS:0] data_r;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SQ_W-1:0]        sq;
  logic                   is_report;

  assign smp       = in_sample[SAMPLE_BITS-1:0];
  assign sq        = SQ_W'(smp) * SQ_W'(smp);
  assign is_report = (in_command == CMD_REPORT);

  assign in_ready = !valid_r || q_ready;
  assign q_valid  = valid_r;
  assign q_data   = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (q_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= {is_report, smp, sq};
    end
  end

endmodule

### sv/imsmm_fifo.sv
// Small register queue between the front end and the accumulator.
module imsmm_fifo #(
  parameter int WIDTH = 73,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  `include "interval_mean_stddev_min_max_assert.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `IMSMM_ASSERT_IMP(a_fifo_depth, 1'b1, cnt_r <= CNT_FULL, "queue fill beyond depth")

endmodule

### sv/imsmm_accum.sv
// Back end accumulator: count, sum, square sum, min and max; hands off a snapshot on report.
module imsmm_accum #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_valid,
  output logic                                     q_ready,
  input  logic [3*SAMPLE_BITS:0]                   q_data,
  output logic                                     snap_valid,
  input  logic                                     snap_ready,
  output logic [COUNT_BITS-1:0]                    snap_count,
  output logic [COUNT_BITS-1:0]                    snap_busiest,
  output logic [SAMPLE_BITS+COUNT_BITS-1:0]        snap_sum,
  output logic [2*SAMPLE_BITS+COUNT_BITS-1:0]      snap_sq,
  output logic [imsmm_pkg::OUT_SAMPLE_W-1:0]       snap_min,
  output logic [SAMPLE_BITS-1:0]                   snap_max,
  output logic                                     snap_ovf
);
  import imsmm_pkg::*;
  `include "interval_mean_stddev_min_max_assert.svh"

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
  localparam int SSQ_W = SQ_W + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0]   count_r, count_nxt;
  logic [COUNT_BITS-1:0]   prev_r, prev_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SSQ_W-1:0]        sq_r, sq_nxt;
  logic [OUT_SAMPLE_W-1:0] min_r, min_nxt;
  logic [SAMPLE_BITS-1:0]  max_r, max_nxt;
  logic                    ovf_r, ovf_nxt;

  logic                    h_report;
  logic [SAMPLE_BITS-1:0]  h_sample;
  logic [SQ_W-1:0]         h_sq;
  logic                    take;

  assign h_report = q_data[3*SAMPLE_BITS];
  assign h_sample = q_data[3*SAMPLE_BITS-1:SQ_W];
  assign h_sq     = q_data[SQ_W-1:0];

  assign snap_valid   = q_valid && h_report;
  assign q_ready      = !h_report || snap_ready;
  assign take         = q_valid && q_ready;

  assign snap_count   = count_r;
  assign snap_busiest = (count_r > prev_r) ? count_r : prev_r;
  assign snap_sum     = sum_r;
  assign snap_sq      = sq_r;
  assign snap_min     = min_r;
  assign snap_max     = max_r;
  assign snap_ovf     = ovf_r;

  always_comb begin
    count_nxt = count_r;
    prev_nxt  = prev_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    ovf_nxt   = ovf_r;
    if (take) begin
      if (h_report) begin
        prev_nxt  = count_r;
        count_nxt = '0;
        sum_nxt   = '0;
        sq_nxt    = '0;
        min_nxt   = MIN_EMPTY;
        max_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else if (count_r == COUNT_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + COUNT_BITS'(1);
        sum_nxt   = sum_r + SUM_W'(h_sample);
        sq_nxt    = sq_r + SSQ_W'(h_sq);
        if (OUT_SAMPLE_W'(h_sample) < min_r) begin
          min_nxt = OUT_SAMPLE_W'(h_sample);
        end
        if (h_sample > max_r) begin
          max_nxt = h_sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      prev_r  <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      min_r   <= MIN_EMPTY;
      max_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  `IMSMM_ASSERT_IMP(a_acc_empty, count_r == '0, (min_r == MIN_EMPTY) && (max_r == '0) && (sum_r == '0), "empty interval not clear")
  `IMSMM_ASSERT_IMP(a_acc_order, count_r != '0, min_r <= OUT_SAMPLE_W'(max_r), "min above max")

endmodule

### sv/imsmm_stats.sv
// Report unit: shared serial divider, square, difference and serial square root.
module imsmm_stats #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  snap_valid,
  output logic                                  snap_ready,
  input  logic [COUNT_BITS-1:0]                 snap_count,
  input  logic [COUNT_BITS-1:0]                 snap_busiest,
  input  logic [SAMPLE_BITS+COUNT_BITS-1:0]     snap_sum,
  input  logic [2*SAMPLE_BITS+COUNT_BITS-1:0]   snap_sq,
  input  logic [imsmm_pkg::OUT_SAMPLE_W-1:0]    snap_min,
  input  logic [SAMPLE_BITS-1:0]                snap_max,
  input  logic                                  snap_ovf,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [imsmm_pkg::OUT_COUNT_W-1:0]     out_sample_count,
  output logic [imsmm_pkg::OUT_SAMPLE_W-1:0]    out_mean,
  output logic [imsmm_pkg::OUT_SAMPLE_W-1:0]    out_minimum,
  output logic [imsmm_pkg::OUT_SAMPLE_W-1:0]    out_maximum,
  output logic [imsmm_pkg::OUT_SAMPLE_W-1:0]    out_std_dev,
  output logic [imsmm_pkg::OUT_COUNT_W-1:0]     out_busiest_count,
  output logic                                  out_overflowed
);
  import imsmm_pkg::*;
  `include "interval_mean_stddev_min_max_assert.svh"

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int DIV_W = SQ_W + COUNT_BITS;
  localparam int STP_W = $clog2(DIV_W);
  localparam logic [STP_W-1:0] STEP_LAST = STP_W'(DIV_W - 1);
  localparam logic [SQ_W-1:0]  SQRT_BIT0 = SQ_W'(1) << (SQ_W - 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_VAR  = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [STP_W-1:0]        step_r, step_nxt;
  logic [COUNT_BITS-1:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]        quo_r, quo_nxt;
  logic [DIV_W-1:0]        sq_hold_r, sq_hold_nxt;
  logic [COUNT_BITS-1:0]   count_r, count_nxt;
  logic [COUNT_BITS-1:0]   busiest_r, busiest_nxt;
  logic [OUT_SAMPLE_W-1:0] min_r, min_nxt;
  logic [SAMPLE_BITS-1:0]  max_r, max_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [SAMPLE_BITS-1:0]  mean_r, mean_nxt;
  logic [SQ_W-1:0]         msq_r, msq_nxt;
  logic [SQ_W-1:0]         sqm_r, sqm_nxt;
  logic [SQ_W-1:0]         v_r, v_nxt;
  logic [SQ_W-1:0]         root_r, root_nxt;
  logic [SQ_W-1:0]         bit_r, bit_nxt;
  logic [SAMPLE_BITS-1:0]  sd_r, sd_nxt;

  logic [COUNT_BITS:0]     trial;
  logic                    ge;
  logic [COUNT_BITS-1:0]   rem_step;
  logic [DIV_W-1:0]        quo_step;
  logic [SQ_W:0]           rb_sum;
  logic                    rb_ge;

  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign ge       = trial >= {1'b0, count_r};
  assign rem_step = ge ? COUNT_BITS'(trial - {1'b0, count_r}) : trial[COUNT_BITS-1:0];
  assign quo_step = {quo_r[DIV_W-2:0], ge};
  assign rb_sum   = {1'b0, root_r} + {1'b0, bit_r};
  assign rb_ge    = {1'b0, v_r} >= rb_sum;

  assign snap_ready = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT);

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    sq_hold_nxt = sq_hold_r;
    count_nxt   = count_r;
    busiest_nxt = busiest_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    ovf_nxt     = ovf_r;
    mean_nxt    = mean_r;
    msq_nxt     = msq_r;
    sqm_nxt     = sqm_r;
    v_nxt       = v_r;
    root_nxt    = root_r;
    bit_nxt     = bit_r;
    sd_nxt      = sd_r;
    case (state_r)
      S_IDLE: begin
        if (snap_valid) begin
          count_nxt   = snap_count;
          busiest_nxt = snap_busiest;
          min_nxt     = snap_min;
          max_nxt     = snap_max;
          ovf_nxt     = snap_ovf;
          quo_nxt     = DIV_W'(snap_sum);
          sq_hold_nxt = snap_sq;
          rem_nxt     = '0;
          step_nxt    = STEP_LAST;
          if (snap_count == '0) begin
            mean_nxt  = '0;
            sd_nxt    = '0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        step_nxt = step_r - STP_W'(1);
        if (step_r == '0) begin
          mean_nxt  = quo_step[SAMPLE_BITS-1:0];
          quo_nxt   = sq_hold_r;
          rem_nxt   = '0;
          step_nxt  = STEP_LAST;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        step_nxt = step_r - STP_W'(1);
        if (step_r == '0) begin
          msq_nxt   = quo_step[SQ_W-1:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        sqm_nxt   = SQ_W'(mean_r) * SQ_W'(mean_r);
        state_nxt = S_VAR;
      end
      S_VAR: begin
        v_nxt     = (msq_r >= sqm_r) ? (msq_r - sqm_r) : (sqm_r - msq_r);
        root_nxt  = '0;
        bit_nxt   = SQRT_BIT0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (rb_ge) begin
          v_nxt    = v_r - rb_sum[SQ_W-1:0];
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == SQ_W'(1)) begin
          sd_nxt    = root_nxt[SAMPLE_BITS-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    sq_hold_r <= sq_hold_nxt;
    count_r   <= count_nxt;
    busiest_r <= busiest_nxt;
    min_r     <= min_nxt;
    max_r     <= max_nxt;
    ovf_r     <= ovf_nxt;
    mean_r    <= mean_nxt;
    msq_r     <= msq_nxt;
    sqm_r     <= sqm_nxt;
    v_r       <= v_nxt;
    root_r    <= root_nxt;
    bit_r     <= bit_nxt;
    sd_r      <= sd_nxt;
  end

  assign out_sample_count  = OUT_COUNT_W'(count_r);
  assign out_mean          = OUT_SAMPLE_W'(mean_r);
  assign out_minimum       = min_r;
  assign out_maximum       = OUT_SAMPLE_W'(max_r);
  assign out_std_dev       = OUT_SAMPLE_W'(sd_r);
  assign out_busiest_count = OUT_COUNT_W'(busiest_r);
  assign out_overflowed    = ovf_r;

  `IMSMM_ASSERT_IMP(a_st_empty, out_valid && (count_r == '0), (mean_r == '0) && (sd_r == '0), "empty report with nonzero stats")
  `IMSMM_ASSERT_IMP(a_st_range, out_valid && (count_r != '0), (min_r <= OUT_SAMPLE_W'(mean_r)) && (mean_r <= max_r), "mean outside min and max")

endmodule

### sv/interval_mean_stddev_min_max.sv
// Sample beats accumulate at one per cycle unless a report stalls them, with a front register
// and a two-entry queue ahead. A report beat runs the bit-serial divider twice, then a square,
// a difference and the bit-serial square root; an empty interval goes straight to its result.
// A following report waits at the queue head until the previous result is taken, stalling
// the beats behind it. Synchronous active-low reset clears all accumulators (minimum to all
// ones) and the queue.
module interval_mean_stddev_min_max #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic [imsmm_pkg::OUT_SAMPLE_W-1:0] in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [imsmm_pkg::OUT_COUNT_W-1:0]  out_sample_count,
  output logic [imsmm_pkg::OUT_SAMPLE_W-1:0] out_mean,
  output logic [imsmm_pkg::OUT_SAMPLE_W-1:0] out_minimum,
  output logic [imsmm_pkg::OUT_SAMPLE_W-1:0] out_maximum,
  output logic [imsmm_pkg::OUT_SAMPLE_W-1:0] out_std_dev,
  output logic [imsmm_pkg::OUT_COUNT_W-1:0]  out_busiest_count,
  output logic                               out_overflowed
);
  import imsmm_pkg::*;

  localparam int ENT_W = 3 * SAMPLE_BITS + 1;

  logic                                fq_valid, fq_ready;
  logic [ENT_W-1:0]                    fq_data;
  logic                                qa_valid, qa_ready;
  logic [ENT_W-1:0]                    qa_data;
  logic                                snap_valid, snap_ready;
  logic [COUNT_BITS-1:0]               snap_count, snap_busiest;
  logic [SAMPLE_BITS+COUNT_BITS-1:0]   snap_sum;
  logic [2*SAMPLE_BITS+COUNT_BITS-1:0] snap_sq;
  logic [OUT_SAMPLE_W-1:0]             snap_min;
  logic [SAMPLE_BITS-1:0]              snap_max;
  logic                                snap_ovf;

  imsmm_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_command),
    .in_sample (in_sample),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_data    (fq_data)
  );

  imsmm_fifo #(
    .WIDTH(ENT_W),
    .DEPTH(2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data (fq_data),
    .pop_valid (qa_valid),
    .pop_ready (qa_ready),
    .pop_data  (qa_data)
  );

  imsmm_accum #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (qa_valid),
    .q_ready     (qa_ready),
    .q_data      (qa_data),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap_count  (snap_count),
    .snap_busiest(snap_busiest),
    .snap_sum    (snap_sum),
    .snap_sq     (snap_sq),
    .snap_min    (snap_min),
    .snap_max    (snap_max),
    .snap_ovf    (snap_ovf)
  );

  imsmm_stats #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk              (clk),
    .rst_n            (rst_n),
    .snap_valid       (snap_valid),
    .snap_ready       (snap_ready),
    .snap_count       (snap_count),
    .snap_busiest     (snap_busiest),
    .snap_sum         (snap_sum),
    .snap_sq          (snap_sq),
    .snap_min         (snap_min),
    .snap_max         (snap_max),
    .snap_ovf         (snap_ovf),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_count (out_sample_count),
    .out_mean         (out_mean),
    .out_minimum      (out_minimum),
    .out_maximum      (out_maximum),
    .out_std_dev      (out_std_dev),
    .out_busiest_count(out_busiest_count),
    .out_overflowed   (out_overflowed)
  );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the interval statistics block: queued stimulus, random stalls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import imsmm_pkg::*;

  localparam int COUNT_BITS    = 16;
  localparam int COUNT_MAX     = (1 << COUNT_BITS) - 1;
  localparam int SILENCE_LIMIT = 20000;
  localparam int DRAIN_CYCLES  = 400;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_ITEMS  = 1630;

  typedef struct packed {
    logic                    cmd;
    logic [OUT_SAMPLE_W-1:0] sample;
  } beat_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0]  count;
    logic [OUT_SAMPLE_W-1:0] mean;
    logic [OUT_SAMPLE_W-1:0] minimum;
    logic [OUT_SAMPLE_W-1:0] maximum;
    logic [OUT_SAMPLE_W-1:0] std_dev;
    logic [OUT_COUNT_W-1:0]  busiest;
    logic                    overflowed;
  } stats_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_command;
  logic [OUT_SAMPLE_W-1:0] in_sample;
  logic                    out_valid;
  logic                    out_ready;
  logic [OUT_COUNT_W-1:0]  out_sample_count;
  logic [OUT_SAMPLE_W-1:0] out_mean;
  logic [OUT_SAMPLE_W-1:0] out_minimum;
  logic [OUT_SAMPLE_W-1:0] out_maximum;
  logic [OUT_SAMPLE_W-1:0] out_std_dev;
  logic [OUT_COUNT_W-1:0]  out_busiest_count;
  logic                    out_overflowed;

  interval_mean_stddev_min_max dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_count (out_sample_count),
    .out_mean         (out_mean),
    .out_minimum      (out_minimum),
    .out_maximum      (out_maximum),
    .out_std_dev      (out_std_dev),
    .out_busiest_count(out_busiest_count),
    .out_overflowed   (out_overflowed)
  );

  beat_t       pending_beats[$];
  stats_t      expected_stats[$];
  int unsigned in_beats;
  int unsigned beats_seen;
  int unsigned errors;
  int unsigned silent_cycles;
  int unsigned calm_lo;
  int unsigned calm_hi;
  int unsigned hold_at;
  int unsigned hold_left;
  bit          hold_done;

  // running interval state
  bit [15:0] acc_count;
  bit [39:0] acc_sum;
  bit [63:0] acc_sq;
  bit [23:0] acc_min;
  bit [23:0] acc_max;
  bit [15:0] last_count;
  bit        acc_ovf;

  wire calm = (in_beats >= calm_lo) && (in_beats < calm_hi);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic bit [63:0] isqrt64(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic clear_interval();
    acc_count = 0;
    acc_sum   = 0;
    acc_sq    = 0;
    acc_min   = MIN_EMPTY;
    acc_max   = 0;
    acc_ovf   = 0;
  endtask

  task automatic absorb_beat(beat_t b);
    bit [63:0] s;
    bit [63:0] mean;
    bit [63:0] mean_of_sq;
    bit [63:0] sq_of_mean;
    bit [63:0] spread;
    stats_t    r;
    s = 64'(b.sample);
    if (b.cmd == CMD_ADD) begin
      if (acc_count >= COUNT_MAX) begin
        acc_ovf = 1'b1;
      end else begin
        acc_count = acc_count + 16'd1;
        acc_sum   = acc_sum + 40'(s);
        acc_sq    = acc_sq + s * s;
        if (b.sample < acc_min) acc_min = b.sample;
        if (b.sample > acc_max) acc_max = b.sample;
      end
    end else begin
      mean   = 0;
      spread = 0;
      if (acc_count != 0) begin
        mean       = 64'(acc_sum) / 64'(acc_count);
        mean_of_sq = acc_sq / 64'(acc_count);
        sq_of_mean = mean * mean;
        spread     = (mean_of_sq >= sq_of_mean) ? mean_of_sq - sq_of_mean
                                                : sq_of_mean - mean_of_sq;
        spread     = isqrt64(spread);
      end
      r.count      = acc_count;
      r.mean       = mean[23:0];
      r.minimum    = acc_min;
      r.maximum    = acc_max;
      r.std_dev    = spread[23:0];
      r.busiest    = (acc_count > last_count) ? acc_count : last_count;
      r.overflowed = acc_ovf;
      expected_stats.push_back(r);
      last_count = acc_count;
      clear_interval();
    end
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic push_add(logic [OUT_SAMPLE_W-1:0] s);
    beat_t b;
    b.cmd    = CMD_ADD;
    b.sample = s;
    pending_beats.push_back(b);
  endtask

  task automatic push_report(logic [OUT_SAMPLE_W-1:0] junk);
    beat_t b;
    b.cmd    = CMD_REPORT;
    b.sample = junk;
    pending_beats.push_back(b);
  endtask

  // sender: new beat only when the current one was taken or none is up
  always @(negedge clk) begin : driver
    beat_t nxt;
    if (rst_n) begin
      if (!in_valid || in_beats != beats_seen) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
          nxt = pending_beats.pop_front();
          in_valid   <= 1'b1;
          in_command <= nxt.cmd;
          in_sample  <= nxt.sample;
        end else begin
          in_valid   <= 1'b0;
          in_command <= 1'($urandom);
          in_sample  <= OUT_SAMPLE_W'($urandom);
        end
      end
      beats_seen = in_beats;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && in_beats >= hold_at) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin : monitor
    stats_t want;
    bit     moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual count 0x%0h",
                   $time, out_sample_count);
          errors++;
        end else begin
          want = expected_stats.pop_front();
          check_field("sample_count", want.count, out_sample_count);
          check_field("mean", want.mean, out_mean);
          check_field("minimum", want.minimum, out_minimum);
          check_field("maximum", want.maximum, out_maximum);
          check_field("std_dev", want.std_dev, out_std_dev);
          check_field("busiest_count", want.busiest, out_busiest_count);
          check_field("overflowed", want.overflowed, out_overflowed);
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        absorb_beat({in_command, in_sample});
        in_beats = in_beats + 1;
      end
      silent_cycles = moved ? 0 : silent_cycles + 1;
      if (silent_cycles >= SILENCE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned len;
    int unsigned style;
    int unsigned start;
    logic [OUT_SAMPLE_W-1:0] base;
    logic [OUT_SAMPLE_W-1:0] s;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_ADD;
    in_sample  = '0;
    out_ready  = 1'b0;
    in_beats   = 0;
    beats_seen = 0;
    errors     = 0;
    silent_cycles = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    last_count = 0;
    clear_interval();

    // empty interval right after reset, report field nonzero
    push_report(24'hFFFFFF);
    // field extremes
    push_add(24'h000000);
    push_add(24'hFFFFFF);
    push_report(24'h000000);
    // empty interval after a busier one
    push_report(24'h5A5A5A);
    push_add(24'd12345);
    push_report(24'hA5A5A5);
    push_add(24'd1);
    push_add(24'd2);
    push_add(24'd3);
    push_add(24'd4);
    push_report(24'h0);
    push_add(24'h800000);
    push_add(24'h7FFFFF);
    push_add(24'h800000);
    push_report(24'h123456);
    push_report(24'h0);
    push_add(24'd77);
    push_report(24'h0);

    start   = pending_beats.size();
    calm_lo = start + 300;
    calm_hi = start + 800;
    hold_at = start + 1100;

    while (pending_beats.size() - start < RANDOM_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        // broken sequences: lone or doubled reports, odd samples
        if ($urandom_range(1)) push_report(OUT_SAMPLE_W'($urandom));
        else push_add(OUT_SAMPLE_W'($urandom));
        if ($urandom_range(3) == 0) push_report(OUT_SAMPLE_W'($urandom));
      end else begin
        len   = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(12);
        style = $urandom_range(4);
        base  = OUT_SAMPLE_W'($urandom);
        for (int i = 0; i < len; i++) begin
          case (style)
            0: s = OUT_SAMPLE_W'($urandom);
            1: s = OUT_SAMPLE_W'($urandom_range(255));
            2: s = 24'hFFFFFF - OUT_SAMPLE_W'($urandom_range(255));
            3: s = base;
            default: s = base ^ (24'd1 << $urandom_range(23));
          endcase
          push_add(s);
        end
        push_report(OUT_SAMPLE_W'($urandom));
      end
    end

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
